### src/kronecker_power_element_defines.svh
// ----------------------------------------------------------------------------
// kronecker power element assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef KRONECKER_POWER_ELEMENT_DEFINES_SVH
`define KRONECKER_POWER_ELEMENT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KPE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define KPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/kpe_pkg.sv
// ----------------------------------------------------------------------------
// kpe_pkg
// types, constants and rounding helper of the kronecker power element
// ----------------------------------------------------------------------------
`default_nettype none

package kpe_pkg;

    localparam int MAX_LEVELS = 16;
    localparam int IDX_W      = 16;
    localparam int LVL_W      = 5;
    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 14;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_NUM    = 8;
    localparam int ENTRY_NUM  = CFG_NUM / 2;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int Q_W        = SUM_W - FRAC_W;

    localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(1 << FRAC_W);
    localparam logic signed [DATA_W-1:0] ZERO_Q = '0;
    localparam logic signed [SUM_W-1:0]  HALF_LSB = SUM_W'(1 << (FRAC_W - 1));
    localparam logic signed [Q_W-1:0]    Q_HI = Q_W'((2 ** (DATA_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]    Q_LO = Q_W'(-(2 ** (DATA_W - 1)));

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [LVL_W-1:0] levels;
    } t_kpe_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] elem_re;
        logic signed [DATA_W-1:0] elem_im;
        logic                     index_error;
    } t_kpe_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_cplx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_last;
    } t_dp_stat;

    // round to nearest, ties up, then clamp to the signed data range
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] t;
        logic signed [Q_W-1:0]   q;
        t = x + HALF_LSB;
        q = t[SUM_W-1:FRAC_W];
        if (q > Q_HI) begin
            round_sat = Q_HI[DATA_W-1:0];
        end else if (q < Q_LO) begin
            round_sat = Q_LO[DATA_W-1:0];
        end else begin
            round_sat = q[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### src/kpe_ctrl.sv
// ----------------------------------------------------------------------------
// kpe_ctrl
// sequencer: one multiply and one accumulate step per level, then result strobe
// ----------------------------------------------------------------------------
`default_nettype none

`include "kronecker_power_element_defines.svh"

module kpe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire kpe_pkg::t_dp_stat i_stat,
    output kpe_pkg::t_dp_cmd       o_cmd,
    output logic                   o_res_valid
);

    kpe_pkg::t_state r_state;
    kpe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kpe_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = kpe_pkg::ST_MUL;
                end
            end
            kpe_pkg::ST_MUL: begin
                if (i_stat.cnt_zero) begin
                    n_state = kpe_pkg::ST_DONE;
                end else begin
                    n_state = kpe_pkg::ST_ACC;
                end
            end
            kpe_pkg::ST_ACC: begin
                if (i_stat.cnt_last) begin
                    n_state = kpe_pkg::ST_DONE;
                end else begin
                    n_state = kpe_pkg::ST_MUL;
                end
            end
            kpe_pkg::ST_DONE: begin
                n_state = kpe_pkg::ST_IDLE;
            end
            default: begin
                n_state = kpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        busy        = 1'b1;
        o_res_valid = 1'b0;
        case (r_state)
            kpe_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            kpe_pkg::ST_MUL: begin
                o_cmd.mul = !i_stat.cnt_zero;
            end
            kpe_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
            end
            kpe_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    `KPE_ASSERT_NEXT(a_last_to_done, r_state == kpe_pkg::ST_ACC && i_stat.cnt_last,
        r_state == kpe_pkg::ST_DONE, "last level did not finish")
    `KPE_ASSERT_NEXT(a_mul_to_acc, r_state == kpe_pkg::ST_MUL && !i_stat.cnt_zero,
        r_state == kpe_pkg::ST_ACC && !o_res_valid, "product not accumulated")

endmodule

`default_nettype wire

### src/kpe_dp.sv
// ----------------------------------------------------------------------------
// kpe_dp
// matrix registers, index and level registers, shared complex multiplier
// ----------------------------------------------------------------------------
`default_nettype none

`include "kronecker_power_element_defines.svh"

module kpe_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire kpe_pkg::t_dp_cmd                  i_cmd,
    output kpe_pkg::t_dp_stat                      o_stat,
    input  wire kpe_pkg::t_kpe_in                  i_in,
    input  wire logic                              i_cfg_we,
    input  wire logic [kpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [kpe_pkg::DATA_W-1:0]        i_cfg_data,
    output kpe_pkg::t_kpe_out                      o_res
);

    kpe_pkg::t_cplx r_mat [kpe_pkg::ENTRY_NUM];

    logic [kpe_pkg::IDX_W-1:0]       r_row;
    logic [kpe_pkg::IDX_W-1:0]       r_col;
    logic [kpe_pkg::CNT_W-1:0]       r_count;
    logic [kpe_pkg::CNT_W-1:0]       n_count;
    logic                            r_err;
    logic                            n_err;
    logic signed [kpe_pkg::DATA_W-1:0] r_acc_re;
    logic signed [kpe_pkg::DATA_W-1:0] r_acc_im;
    logic signed [kpe_pkg::PROD_W-1:0] r_p_rr;
    logic signed [kpe_pkg::PROD_W-1:0] r_p_ii;
    logic signed [kpe_pkg::PROD_W-1:0] r_p_ir;
    logic signed [kpe_pkg::PROD_W-1:0] r_p_ri;

    logic [kpe_pkg::CNT_W-1:0]       bit_pos;
    logic                            row_bit;
    logic                            col_bit;
    kpe_pkg::t_cplx                  entry;
    logic signed [kpe_pkg::SUM_W-1:0] sum_re;
    logic signed [kpe_pkg::SUM_W-1:0] sum_im;

    // matrix registers, two words per complex entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < kpe_pkg::ENTRY_NUM; e++) begin
                r_mat[e].re <= (e == 0 || e == kpe_pkg::ENTRY_NUM - 1) ?
                               kpe_pkg::ONE_Q : kpe_pkg::ZERO_Q;
                r_mat[e].im <= kpe_pkg::ZERO_Q;
            end
        end else if (i_cfg_we && (int'(i_cfg_index) < kpe_pkg::CFG_NUM)) begin
            if (i_cfg_index[0]) begin
                r_mat[i_cfg_index[2:1]].im <= i_cfg_data;
            end else begin
                r_mat[i_cfg_index[2:1]].re <= i_cfg_data;
            end
        end
    end

    // level clamp and index range check at load
    always_comb begin
        if (int'(i_in.levels) > kpe_pkg::MAX_LEVELS) begin
            n_count = kpe_pkg::CNT_W'(kpe_pkg::MAX_LEVELS);
        end else begin
            n_count = kpe_pkg::CNT_W'(i_in.levels);
        end
        n_err = ((i_in.row_index >> n_count) != '0) || ((i_in.col_index >> n_count) != '0);
    end

    // entry select from the current index bits
    always_comb begin
        bit_pos = r_count - kpe_pkg::CNT_W'(1);
        row_bit = 1'(r_row >> bit_pos);
        col_bit = 1'(r_col >> bit_pos);
        entry   = r_mat[{row_bit, col_bit}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= n_count;
        end else if (i_cmd.acc) begin
            r_count <= r_count - kpe_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row    <= i_in.row_index;
            r_col    <= i_in.col_index;
            r_err    <= n_err;
            r_acc_re <= kpe_pkg::ONE_Q;
            r_acc_im <= kpe_pkg::ZERO_Q;
        end else if (i_cmd.acc) begin
            r_acc_re <= kpe_pkg::round_sat(sum_re);
            r_acc_im <= kpe_pkg::round_sat(sum_im);
        end
    end

    // partial products of the complex multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_rr <= r_acc_re * entry.re;
            r_p_ii <= r_acc_im * entry.im;
            r_p_ir <= r_acc_im * entry.re;
            r_p_ri <= r_acc_re * entry.im;
        end
    end

    assign sum_re = kpe_pkg::SUM_W'(r_p_rr) - kpe_pkg::SUM_W'(r_p_ii);
    assign sum_im = kpe_pkg::SUM_W'(r_p_ir) + kpe_pkg::SUM_W'(r_p_ri);

    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_last = (r_count == kpe_pkg::CNT_W'(1));

    assign o_res.elem_re     = r_acc_re;
    assign o_res.elem_im     = r_acc_im;
    assign o_res.index_error = r_err;

    `KPE_ASSERT_SAME(a_acc_count, i_cmd.acc || i_cmd.mul, r_count != '0,
        "level step with no level left")
    `KPE_ASSERT_NEXT(a_load_clamp, i_cmd.load,
        int'(r_count) <= kpe_pkg::MAX_LEVELS, "level count beyond limit")

endmodule

`default_nettype wire

### src/kronecker_power_element.sv
// ----------------------------------------------------------------------------
// kronecker_power_element
// one element of the k-fold kronecker power of a configured 2x2 complex matrix
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each of the k levels
// (k clamped to 16) takes a multiply step (ST_MUL) on the shared complex
// multiplier, then a round-and-accumulate step (ST_ACC); the result strobe
// o_res_valid rises after the last ST_ACC (after ST_MUL for k = 0) and lasts
// exactly one cycle; the receiver cannot stall, so results must be captured
// then. busy drops the cycle after the strobe; only then is a new item taken.
// Matrix registers are written through the cfg channel, which is always
// ready; write them only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module kronecker_power_element (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire kpe_pkg::t_kpe_in              i_in,
    output logic                               o_res_valid,
    output kpe_pkg::t_kpe_out                  o_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [kpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kpe_pkg::DATA_W-1:0]    i_cfg_data
);

    kpe_pkg::t_dp_cmd  cmd;
    kpe_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    kpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_res_valid (o_res_valid)
    );

    kpe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
